// ===== rtl/desks_pkg.sv =====
package desks_pkg;

	localparam int KeyBits   = 64;
	localparam int HalfBits  = 28;
	localparam int CdBits    = 2 * HalfBits;
	localparam int SubBits   = 48;
	localparam int RoundBits = 5;
	localparam int IdxBits   = 4;
	localparam int Rounds    = 16;

	localparam logic [RoundBits-1:0] LastRound = RoundBits'(Rounds);

	// Bit positions are 1-based, 1 being the most significant bit.
	localparam logic [7:0] PC1_TAB [CdBits] = '{
		8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
		8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
		8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
		8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
		8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
		8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
		8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
		8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
	};

	localparam logic [7:0] PC2_TAB [SubBits] = '{
		8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
		8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
		8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
		8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
		8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
		8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
		8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
		8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
	};

	typedef struct packed {
		logic                 valid;
		logic [RoundBits-1:0] round_number;
		logic                 last;
	} round_ctl_t;

	function automatic logic [CdBits-1:0] pc1(input logic [KeyBits-1:0] key);
		logic [CdBits-1:0] res;
		res = '0;
		for (int i = 0; i < CdBits; i++) begin
			res[CdBits-1-i] = key[KeyBits - int'(PC1_TAB[i])];
		end
		return res;
	endfunction

	function automatic logic [SubBits-1:0] pc2(input logic [CdBits-1:0] cd);
		logic [SubBits-1:0] res;
		res = '0;
		for (int i = 0; i < SubBits; i++) begin
			res[SubBits-1-i] = cd[CdBits - int'(PC2_TAB[i])];
		end
		return res;
	endfunction

	// single-place rotation in rounds 1, 2, 9 and 16
	function automatic logic single_shift(input logic [RoundBits-1:0] rnd);
		return (rnd == RoundBits'(1)) || (rnd == RoundBits'(2)) ||
			(rnd == RoundBits'(9)) || (rnd == RoundBits'(16));
	endfunction

	function automatic logic [HalfBits-1:0] rotl(input logic [HalfBits-1:0] h,
		input logic one);
		return one ? {h[HalfBits-2:0], h[HalfBits-1]} :
			{h[HalfBits-3:0], h[HalfBits-1:HalfBits-2]};
	endfunction

endpackage

// ===== rtl/des_key_schedule.sv =====
// DES key schedule.
// Slave stream: one 64-bit key per transaction on s_axis_tdata, standard bit 1
// in bit 63; parity bits are ignored.
// Master stream: sixteen transactions per key, one subkey each, in round order.
// tdata carries the 48-bit subkey, tuser the round number 1..16, and tlast
// marks round 16.
// Throughput: one subkey per cycle while keys are waiting and tready is high; the
// single round register pair (C and D halves), rotating once per subkey, sets this.
// A second key is taken into the input stage while the previous one is still
// being expanded, and its rounds follow the previous key's last round with no
// idle cycle.
// Pipeline: PC1 input register, round register, PC2 output register.
// When the receiver holds tready low, the output register holds its
// transaction, the stages behind it stop and then s_axis_tready falls.
// Reset empties all stages; no key is kept across reset.
module des_key_schedule (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] cipher_key
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [47:0] round_subkey
	output logic [4:0]  m_axis_tuser,  // [4:0] round_number
	output logic        m_axis_tlast   // final_round
);

	logic                                 valid_s1;
	logic [desks_pkg::CdBits-1:0]         cd_s1;
	logic                                 take;
	logic                                 ready_s2;
	desks_pkg::round_ctl_t                ctl_s2;
	logic [desks_pkg::CdBits-1:0]         cd_s2;
	desks_pkg::round_ctl_t                ctl_s3;
	logic [desks_pkg::SubBits-1:0]        sub_s3;

	desks_pc1 u_pc1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_key   (s_axis_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.cd_s1    (cd_s1)
	);

	desks_rounds u_rounds (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.cd_s1      (cd_s1),
		.take       (take),
		.down_ready (ready_s2),
		.ctl_s2     (ctl_s2),
		.cd_s2      (cd_s2)
	);

	desks_pc2 u_pc2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s2    (ctl_s2),
		.cd_s2     (cd_s2),
		.ready_s2  (ready_s2),
		.ctl_s3    (ctl_s3),
		.sub_s3    (sub_s3),
		.out_ready (m_axis_tready)
	);

	assign m_axis_tvalid = ctl_s3.valid;
	assign m_axis_tdata  = sub_s3;
	assign m_axis_tuser  = ctl_s3.round_number;
	assign m_axis_tlast  = ctl_s3.last;

endmodule

// ===== rtl/desks_pc1.sv =====
module desks_pc1 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [desks_pkg::KeyBits-1:0]      in_key,
	input  logic                               take,
	output logic                               valid_s1,
	output logic [desks_pkg::CdBits-1:0]       cd_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cd_s1 <= desks_pkg::pc1(in_key);
		end
	end

endmodule

// ===== rtl/desks_rounds.sv =====
module desks_rounds (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid_s1,
	input  logic [desks_pkg::CdBits-1:0]       cd_s1,
	output logic                               take,
	input  logic                               down_ready,
	output desks_pkg::round_ctl_t              ctl_s2,
	output logic [desks_pkg::CdBits-1:0]       cd_s2
);

	logic                                 active_q;
	logic [desks_pkg::IdxBits-1:0]        rnd_q;
	logic [desks_pkg::HalfBits-1:0]       c_q;
	logic [desks_pkg::HalfBits-1:0]       d_q;
	logic                                 valid_s2;
	logic [desks_pkg::RoundBits-1:0]      round_s2;
	logic                                 last_s2;
	logic                                 adv;
	logic                                 fire;
	logic                                 last;
	logic [desks_pkg::RoundBits-1:0]      rnd_num;
	logic                                 one;
	logic [desks_pkg::HalfBits-1:0]       c_rot;
	logic [desks_pkg::HalfBits-1:0]       d_rot;

	assign ctl_s2  = '{valid: valid_s2, round_number: round_s2, last: last_s2};
	assign adv     = !valid_s2 || down_ready;
	assign fire    = active_q && adv;
	assign last    = rnd_q == desks_pkg::IdxBits'(desks_pkg::Rounds - 1);
	assign rnd_num = desks_pkg::RoundBits'(rnd_q) + desks_pkg::RoundBits'(1);
	assign one     = desks_pkg::single_shift(rnd_num);
	assign c_rot   = desks_pkg::rotl(c_q, one);
	assign d_rot   = desks_pkg::rotl(d_q, one);
	// next key is loaded as the sixteenth round leaves, so keys run without a gap
	assign take    = !active_q || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rnd_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= fire;
			end
			if (take) begin
				active_q <= valid_s1;
				rnd_q    <= '0;
			end else if (fire) begin
				rnd_q <= rnd_q + desks_pkg::IdxBits'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && valid_s1) begin
			c_q <= cd_s1[desks_pkg::CdBits-1:desks_pkg::HalfBits];
			d_q <= cd_s1[desks_pkg::HalfBits-1:0];
		end else if (fire) begin
			c_q <= c_rot;
			d_q <= d_rot;
		end
		if (fire) begin
			cd_s2    <= {c_rot, d_rot};
			round_s2 <= rnd_num;
			last_s2  <= last;
		end
	end

endmodule

// ===== rtl/desks_pc2.sv =====
module desks_pc2 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  desks_pkg::round_ctl_t              ctl_s2,
	input  logic [desks_pkg::CdBits-1:0]       cd_s2,
	output logic                               ready_s2,
	output desks_pkg::round_ctl_t              ctl_s3,
	output logic [desks_pkg::SubBits-1:0]      sub_s3,
	input  logic                               out_ready
);

	logic                                 valid_s3;
	logic [desks_pkg::RoundBits-1:0]      round_s3;
	logic                                 last_s3;

	assign ctl_s3   = '{valid: valid_s3, round_number: round_s3, last: last_s3};
	assign ready_s2 = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && ctl_s2.valid) begin
			sub_s3   <= desks_pkg::pc2(cd_s2);
			round_s3 <= ctl_s2.round_number;
			last_s3  <= ctl_s2.last;
		end
	end

endmodule

// ===== rtl/desks_checker.sv =====
module desks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [4:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("stalled output changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == desks_pkg::LastRound)))
		else $error("tlast does not match round 16");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != 5'd0) && (m_axis_tuser <= desks_pkg::LastRound))
		else $error("round number out of range");

	// rounds of one key come back to back in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) ##1 m_axis_tvalid |->
			m_axis_tuser == $past(m_axis_tuser) + 5'd1)
		else $error("round out of order");

	// the next round of a key is always ready right behind the one taken
	a_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside the rounds of a key");

endmodule

bind des_key_schedule desks_checker u_desks_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
